@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the route table lookup RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, muted while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

@@ src/iprt_pkg.sv @@
// ----------------------------------------------------------------------------
// iprt_pkg
// Shared types and codes for the IPv4 route table lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package iprt_pkg;

	// item command codes
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	// one route table entry
	typedef struct packed {
		logic [31:0] net;
		logic [31:0] mask;
		logic [31:0] iface;
	} iprt_entry_t;

endpackage

`default_nettype wire

@@ src/iprt_table.sv @@
// ----------------------------------------------------------------------------
// iprt_table
// Route table memory: append-only write port, one registered read port,
// entry count and a copy of entry 0's interface for the miss case.
// ----------------------------------------------------------------------------
`default_nettype none

module iprt_table #(
	parameter int ENTRIES = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              wr_en,
	input  iprt_pkg::iprt_entry_t            wr_entry,
	input  wire [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
	output iprt_pkg::iprt_entry_t            rd_entry,
	output logic [$clog2(ENTRIES + 1)-1:0]   count,
	output logic [31:0]                      iface0
);
	import iprt_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	iprt_entry_t            mem [0:ENTRIES-1];
	iprt_entry_t            rd_q;
	logic [CNT_W-1:0]       count_q;
	logic [31:0]            iface0_q;
	logic                   wr_ok;

	// a load into a full table is dropped
	assign wr_ok = wr_en && (count_q < CNT_W'(ENTRIES));

	// entry storage, read data registered
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[count_q[IDX_W-1:0]] <= wr_entry;
		end
		rd_q <= mem[rd_addr];
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr_ok) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// default interface for a miss
	always_ff @(posedge clk) begin
		if (wr_ok && (count_q == '0)) begin
			iface0_q <= wr_entry.iface;
		end
	end

	assign rd_entry = rd_q;
	assign count    = count_q;
	assign iface0   = iface0_q;

endmodule

`default_nettype wire

@@ src/iprt_ctrl.sv @@
// ----------------------------------------------------------------------------
// iprt_ctrl
// Lookup sequencer: steps the table read address once per cycle and runs
// each returned entry through one shared network/mask comparator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module iprt_ctrl #(
	parameter int ENTRIES = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire                              mode,
	input  wire [31:0]                       address,
	input  wire [31:0]                       net_mask,
	output logic                             busy,
	output logic                             wr_en,
	output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
	input  iprt_pkg::iprt_entry_t            rd_entry,
	input  wire [$clog2(ENTRIES + 1)-1:0]    count,
	input  wire [31:0]                       iface0,
	output logic [31:0]                      network,
	output logic [31:0]                      interface_addr,
	output logic                             hit,
	output logic                             done
);
	import iprt_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              pend_q;
	logic              done_q;
	logic [31:0]       net_q;
	logic [31:0]       mask_q;
	logic [31:0]       iface_q;
	logic              hit_q;
	logic              accept;
	logic              match;
	logic              more;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign wr_en  = accept && (mode == MODE_LOAD);

	// entry 0 is read on the accept edge, then one entry per cycle
	assign rd_addr = (state_q == ST_SCAN) ? rd_idx_q[IDX_W-1:0] : '0;
	assign more    = (rd_idx_q < count);

	// shared comparator on the entry returned this cycle
	assign match = (rd_entry.net == net_q) && (rd_entry.mask == mask_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			pend_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (mode == MODE_LOOKUP)) begin
						if (count == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q  <= ST_SCAN;
							rd_idx_q <= CNT_W'(1);
							pend_q   <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if ((pend_q && match) || !pend_q) begin
						done_q  <= 1'b1;
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						pend_q <= more;
						if (more) begin
							rd_idx_q <= rd_idx_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					pend_q  <= 1'b0;
				end
			endcase
		end
	end

	// lookup key, held until the result has gone out
	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_LOOKUP)) begin
			net_q  <= address & net_mask;
			mask_q <= net_mask;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_LOOKUP) && (count == '0)) begin
			iface_q <= '0;
			hit_q   <= 1'b0;
		end else if ((state_q == ST_SCAN) && pend_q && match) begin
			iface_q <= rd_entry.iface;
			hit_q   <= 1'b1;
		end else if ((state_q == ST_SCAN) && !pend_q) begin
			iface_q <= iface0;
			hit_q   <= 1'b0;
		end
	end

	assign network        = net_q;
	assign interface_addr = iface_q;
	assign hit            = hit_q;
	assign done           = done_q;

	// checks
	`ASSERT_CLK(a_done_idle, clk, arst_n, done_q |-> (state_q == ST_IDLE), "result while scanning")
	`ASSERT_CLK(a_idx_bound, clk, arst_n, (state_q == ST_SCAN) |-> (rd_idx_q <= count), "scan past fill count")
	`ASSERT_CLK(a_hit_pend, clk, arst_n, (done_q && hit_q) |-> $past(pend_q), "hit without a pending entry")
	`ASSERT_NEVER(a_load_busy, clk, arst_n, wr_en && busy, "load taken during a scan")

endmodule

`default_nettype wire

@@ src/ipv4_route_table_lookup_top.sv @@
// A load gives no result. A lookup strobes done when the scan hits an entry,
// or after the last filled entry on a miss, or without a scan when the table
// is empty. Busy is high for the scan, which reads one entry per cycle
// through the table's single read port into one comparator.
// One load per cycle while busy is low; no item is taken while a scan runs.
// Reset clears the fill count and sequencer; the table needs no clearing pass.
`default_nettype none

module ipv4_route_table_lookup_top #(
	parameter int ENTRIES = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         mode,
	input  wire [31:0]  address,
	input  wire [31:0]  net_mask,
	input  wire [31:0]  out_interface,
	output logic        done,
	output logic [31:0] network,
	output logic [31:0] interface_addr,
	output logic        hit
);
	import iprt_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic              wr_en;
	iprt_entry_t       wr_entry;
	logic [IDX_W-1:0]  rd_addr;
	iprt_entry_t       rd_entry;
	logic [CNT_W-1:0]  count;
	logic [31:0]       iface0;

	// entry formed straight from the item fields
	assign wr_entry.net   = address;
	assign wr_entry.mask  = net_mask;
	assign wr_entry.iface = out_interface;

	iprt_table #(
		.ENTRIES (ENTRIES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.count    (count),
		.iface0   (iface0)
	);

	iprt_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.mode           (mode),
		.address        (address),
		.net_mask       (net_mask),
		.busy           (busy),
		.wr_en          (wr_en),
		.rd_addr        (rd_addr),
		.rd_entry       (rd_entry),
		.count          (count),
		.iface0         (iface0),
		.network        (network),
		.interface_addr (interface_addr),
		.hit            (hit),
		.done           (done)
	);

endmodule

`default_nettype wire
